>>> sv/dssm_pkg.sv
// Package with payload types and opcodes for the drum step sequencer mixer.
`default_nettype none
package dssm_pkg;

  typedef enum logic [2:0] {
    OP_GENERATE = 3'd0,
    OP_WAVE     = 3'd1,
    OP_SOUND    = 3'd2,
    OP_PATTERN  = 3'd3,
    OP_VOICE    = 3'd4,
    OP_ARRANGE  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    REG_SAMPLES_PER_TICK = 2'd0,
    REG_STEPS_PER_BAR    = 2'd1,
    REG_LOOP_LEN         = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        wave_address;
    logic signed [15:0] wave_value;
    logic [2:0]         sound_id;
    logic [15:0]        sound_length;
    logic [2:0]         voice_id;
    logic [1:0]         pattern_id;
    logic [6:0]         step_index;
    logic [3:0]         hit_level;
    logic [5:0]         pan;
    logic [7:0]         volume;
    logic [3:0]         bar_slot;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } out_item_t;

  localparam int unsigned CFG_WIDTH = 16;

endpackage
`default_nettype wire

>>> sv/drum_step_sequencer_mixer_top.sv
// Drum step sequencer mixer: sample playback voices, step pattern and stereo mix.
//
// Usage: input beats arrive on in_valid/in_stall/in_data. Opcodes one to five load
// the wave memory, the sound table, pattern cells, voice settings and the bar
// arrangement and give no output beat. Opcode zero produces one stereo frame on
// out_valid/out_stall/out_data. Configuration registers are written through
// cfg_write/cfg_index/cfg_data; the user must do so only while the block is idle,
// since the block itself does not enforce it. A load finishes in S_PAT and returns
// to idle. A frame runs the voice loop, then raises out_valid from the final state
// as the block returns to idle. In the voice loop each voice passes through a
// pattern memory read, a wave memory read and one pass through the shared
// multiplier; the last product is then accumulated and the frame registered.
// The block works on one beat at a time. The finished frame sits in an output
// register, so the next beat is taken while the frame waits for the receiver; a
// second frame waits in the final state until the register frees up.
// Reset: control state clears at once, then a clearing pass zeroes all
// PATTERNS*VOICES*STEPS pattern memory cells (1728 by default) with the input
// stalled. Wave memory and the sound table are undefined until written.
`default_nettype none
module drum_step_sequencer_mixer_top
  import dssm_pkg::*;
#(
  parameter int VOICES        = 6,
  parameter int STEPS         = 72,
  parameter int ARRANGE_SLOTS = 16,
  parameter int WAVE_DEPTH    = 65536,
  parameter int PATTERNS      = 4,
  parameter int SOUNDS        = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire in_item_t       in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output out_item_t           out_data,
  input  wire logic           cfg_write,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SW   = (SOUNDS > 1) ? $clog2(SOUNDS) : 1;
  localparam int PW   = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int AW   = (ARRANGE_SLOTS > 1) ? $clog2(ARRANGE_SLOTS) : 1;
  localparam int WW   = (WAVE_DEPTH > 1) ? $clog2(WAVE_DEPTH) : 1;
  localparam int ROWS = PATTERNS * VOICES;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PD   = ROWS * STEPS;
  localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;

  // Configuration.
  logic [15:0] samples_per_tick;
  logic [6:0]  steps_per_bar;
  logic [4:0]  loop_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_tick <= 16'd948;
      steps_per_bar    <= 7'd72;
      loop_len         <= 5'd10;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_TICK: samples_per_tick <= cfg_data[15:0];
        REG_STEPS_PER_BAR:    steps_per_bar    <= cfg_data[6:0];
        REG_LOOP_LEN:         loop_len         <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [15:0] spt_eff;
  logic [6:0]  spb_eff;
  logic [4:0]  lb_eff;
  always_comb begin
    spt_eff = (samples_per_tick == 16'd0) ? 16'd1 : samples_per_tick;
    spb_eff = (steps_per_bar == 7'd0) ? 7'd1 :
              ((32'(steps_per_bar) > STEPS) ? 7'(STEPS) : steps_per_bar);
    lb_eff  = (loop_len == 5'd0) ? 5'd1 :
              ((32'(loop_len) > ARRANGE_SLOTS) ? 5'(ARRANGE_SLOTS) : loop_len);
  end

  // Memories.
  logic signed [15:0] wave_mem [WAVE_DEPTH];
  logic [3:0]         pat_mem  [PD];

  // Small per-entry tables in flip-flops.
  logic [15:0]   sound_start [SOUNDS];
  logic [15:0]   sound_size  [SOUNDS];
  logic [PW-1:0] arrange     [ARRANGE_SLOTS];
  logic [5:0]    voice_pan   [VOICES];
  logic [7:0]    voice_vol   [VOICES];
  logic [SW-1:0] voice_snd   [VOICES];
  logic [15:0]   voice_pos   [VOICES];
  logic [6:0]    voice_emph  [VOICES];

  logic [15:0] frame_counter;
  logic [6:0]  step_counter;
  logic [3:0]  bar_counter;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PAT, S_WAVE, S_MAC, S_FINAL
  } state_t;
  state_t state;

  in_item_t    item;
  logic [VW-1:0] vidx;
  logic          first_frame;
  logic [PW-1:0] cur_pat;
  logic [PAW-1:0] clr_addr;
  logic signed [47:0] acc_l, acc_r;
  logic [3:0]    hit_cell;
  logic signed [24:0] prod;    // sample * gain
  logic [5:0]    prod_pan;
  logic          prod_valid;

  // Pattern address for the current voice at the current step. The step counter
  // always stays below STEPS, since its limit is clamped to STEPS.
  logic [PAW-1:0] pat_rd_addr;
  logic [RW-1:0]  pat_row;
  always_comb begin
    pat_row     = RW'(32'(cur_pat) * VOICES + 32'(vidx));
    pat_rd_addr = PAW'(32'(pat_row) * STEPS + 32'(step_counter));
  end

  logic [3:0]     pat_q;
  always_ff @(posedge clk) begin
    pat_q <= pat_mem[pat_rd_addr];
  end
  assign hit_cell = pat_q;

  // Position after a possible retrigger.
  logic [15:0] pos_eff;
  logic [6:0]  emph_eff;
  logic [SW-1:0] snd_cur;
  logic [15:0] wave_rd_addr;
  always_comb begin
    snd_cur  = voice_snd[vidx];
    pos_eff  = voice_pos[vidx];
    emph_eff = voice_emph[vidx];
    if (first_frame && hit_cell != 4'd0) begin
      pos_eff  = 16'd1;
      emph_eff = 7'(hit_cell - 4'd1) * 7'd12;
    end
    wave_rd_addr = sound_start[snd_cur] + pos_eff;
  end

  logic signed [15:0] wave_q;
  logic               wave_oob;
  always_ff @(posedge clk) begin
    wave_q   <= wave_mem[wave_rd_addr[WW-1:0]];
    wave_oob <= 32'(wave_rd_addr) >= WAVE_DEPTH;
  end

  // Load writes into the memories.
  logic load_fire;
  logic [PAW-1:0] pat_wr_addr;
  logic [RW-1:0]  pat_wr_row;
  assign load_fire = (state == S_PAT) && (item.opcode != OP_GENERATE);
  always_comb begin
    pat_wr_row  = RW'(32'(item.pattern_id) * VOICES + 32'(item.voice_id));
    pat_wr_addr = PAW'(32'(pat_wr_row) * STEPS + 32'(item.step_index));
  end

  always_ff @(posedge clk) begin
    if (load_fire && item.opcode == OP_WAVE && 32'(item.wave_address) < WAVE_DEPTH) begin
      wave_mem[item.wave_address[WW-1:0]] <= item.wave_value;
    end
    if (state == S_CLEAR) begin
      pat_mem[clr_addr] <= 4'd0;
    end else if (load_fire && item.opcode == OP_PATTERN && 32'(item.pattern_id) < PATTERNS &&
                 32'(item.voice_id) < VOICES && 32'(item.step_index) < STEPS) begin
      pat_mem[pat_wr_addr] <= (item.hit_level > 4'd9) ? 4'd9 : item.hit_level;
    end
  end

  // Mix result.
  logic signed [47:0] div_l, div_r;
  logic signed [15:0] sat_l, sat_r;
  always_comb begin
    div_l = (acc_l < 0) ? -((-acc_l) >>> 15) : (acc_l >>> 15);
    div_r = (acc_r < 0) ? -((-acc_r) >>> 15) : (acc_r >>> 15);
    sat_l = (div_l > 48'sd32767) ? 16'sh7fff :
            ((div_l < -48'sd32768) ? 16'sh8000 : div_l[15:0]);
    sat_r = (div_r > 48'sd32767) ? 16'sh7fff :
            ((div_r < -48'sd32768) ? 16'sh8000 : div_r[15:0]);
  end

  assign in_stall = (state != S_IDLE);
  logic last_voice;
  assign last_voice = (32'(vidx) == VOICES - 1);

  // Emphasis plus volume reaches 351, so the gain needs nine magnitude bits.
  logic [8:0]         gain_mag;
  logic signed [9:0]  gain;
  assign gain_mag = 9'(emph_eff) + 9'(voice_vol[vidx]);
  assign gain     = $signed({1'b0, gain_mag});

  logic [15:0] fc_inc;
  assign fc_inc = frame_counter + 16'd1;

  logic frame_done;
  assign frame_done = (state == S_FINAL) && !prod_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      frame_counter <= '0;
      step_counter  <= '0;
      bar_counter   <= '0;
      prod_valid    <= 1'b0;
      for (int a = 0; a < ARRANGE_SLOTS; a++) arrange[a] <= '0;
      for (int v = 0; v < VOICES; v++) begin
        voice_pan[v]  <= 6'd16;
        voice_vol[v]  <= '0;
        voice_snd[v]  <= '0;
        voice_pos[v]  <= '0;
        voice_emph[v] <= '0;
      end
    end else begin
      prod_valid <= (state == S_MAC);
      if (frame_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (prod_valid) begin
        acc_l <= acc_l + 48'(prod) * 48'($signed({1'b0, prod_pan}));
        acc_r <= acc_r + 48'(prod) * 48'($signed({1'b0, 6'd32 - prod_pan}));
      end
      unique case (state)
        S_CLEAR: begin
          if (32'(clr_addr) == PD - 1) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + PAW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item        <= in_data;
            vidx        <= '0;
            first_frame <= (frame_counter == 16'd0);
            cur_pat     <= arrange[bar_counter[AW-1:0]];
            acc_l       <= '0;
            acc_r       <= '0;
            state       <= S_PAT;
          end
        end
        S_PAT: begin
          if (item.opcode == OP_GENERATE) begin
            state <= S_WAVE;
          end else begin
            state <= S_IDLE;
            unique case (item.opcode)
              OP_SOUND: if (32'(item.sound_id) < SOUNDS) begin
                sound_start[item.sound_id[SW-1:0]] <= item.wave_address;
                sound_size[item.sound_id[SW-1:0]]  <= item.sound_length;
              end
              OP_VOICE: if (32'(item.voice_id) < VOICES) begin
                voice_pan[item.voice_id[VW-1:0]] <= (item.pan > 6'd32) ? 6'd32 : item.pan;
                voice_vol[item.voice_id[VW-1:0]] <= item.volume;
                voice_snd[item.voice_id[VW-1:0]] <= SW'(32'(item.sound_id) % SOUNDS);
              end
              OP_ARRANGE: if (32'(item.bar_slot) < ARRANGE_SLOTS &&
                              32'(item.pattern_id) < PATTERNS)
                arrange[item.bar_slot[AW-1:0]] <= item.pattern_id[PW-1:0];
              default: ;
            endcase
          end
        end
        S_WAVE: begin
          // Wave read is issued this cycle; commit the voice update.
          voice_emph[vidx] <= emph_eff;
          if (pos_eff != 16'd0) begin
            voice_pos[vidx] <= ((pos_eff + 16'd1) >= sound_size[snd_cur]) ? 16'd0
                                                                          : pos_eff + 16'd1;
          end else begin
            voice_pos[vidx] <= 16'd0;
          end
          state <= S_MAC;
        end
        S_MAC: begin
          prod     <= 25'(wave_oob ? 16'sd0 : wave_q) * 25'(gain);
          prod_pan <= voice_pan[vidx];
          if (last_voice) begin
            state <= S_FINAL;
          end else begin
            vidx  <= vidx + VW'(1);
            state <= S_PAT;
          end
        end
        S_FINAL: begin
          if (frame_done) begin
            out_data  <= '{left_sample: sat_l, right_sample: sat_r};
            state     <= S_IDLE;
            if (fc_inc >= spt_eff) begin
              frame_counter <= '0;
              if (step_counter + 7'd1 >= spb_eff) begin
                step_counter <= '0;
                if (5'(bar_counter) + 5'd1 >= lb_eff) bar_counter <= '0;
                else bar_counter <= bar_counter + 4'd1;
              end else begin
                step_counter <= step_counter + 7'd1;
              end
            end else begin
              frame_counter <= fc_inc;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted beat while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("output frame lost under stall");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    32'(step_counter) < STEPS) else $error("step counter out of range");
  a_no_acc_in_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !prod_valid) else $error("pending product in idle");
  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid) else $error("output beat during clearing pass");

endmodule
`default_nettype wire

>>> dv/drum_step_sequencer_mixer_top_tb.sv
// Self-checking testbench for the drum step sequencer mixer with a built-in frame predictor.
`timescale 1ns / 100ps
module drum_step_sequencer_mixer_top_tb;
  import dssm_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int VOICE_CNT = 6;
  localparam int N_STEPS  = 72;
  localparam int N_SLOTS  = 16;
  // Sounds start at or below SND_START_MAX and last at most SND_LEN_MAX samples, so every
  // read lands in the low wave region or in the top words for the wrapping sound.
  localparam int SND_START_MAX = 127;
  localparam int SND_LEN_MAX   = 64;
  localparam int LOW_WORDS     = 192;
  localparam int TOP_WORDS     = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  drum_step_sequencer_mixer_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Mirror of the machine state.
  logic signed [15:0] wave_mem [65536];
  logic [15:0] snd_start [8];
  logic [15:0] snd_len [8];
  logic [3:0] hit_grid [4][VOICE_CNT][N_STEPS];
  logic [1:0] arrange [N_SLOTS];
  int v_pan [VOICE_CNT];
  int v_vol [VOICE_CNT];
  int v_snd [VOICE_CNT];
  int v_pos [VOICE_CNT];
  int v_emph [VOICE_CNT];
  int frame_cnt, step_cnt, bar_cnt;
  int spt_reg, spb_reg, lb_reg;

  in_item_t pending_beats [$];
  out_item_t expected_frames [$];
  int errors = 0;
  int frames_checked = 0;
  int beats_sent = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  function automatic logic signed [15:0] sat16(longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic void mix_frame();
    int spt_e, spb_e, lb_e, p, c, sn, addr, np, vol;
    longint left, right, smp;
    out_item_t f;
    spt_e = (spt_reg == 0) ? 1 : spt_reg;
    spb_e = (spb_reg < 1) ? 1 : (spb_reg > N_STEPS ? N_STEPS : spb_reg);
    lb_e = (lb_reg < 1) ? 1 : (lb_reg > N_SLOTS ? N_SLOTS : lb_reg);
    left = 0;
    right = 0;
    if (frame_cnt == 0) begin
      p = arrange[bar_cnt % N_SLOTS];
      for (int v = 0; v < VOICE_CNT; v++) begin
        c = hit_grid[p][v][step_cnt % N_STEPS];
        if (c != 0) begin
          v_pos[v] = 1;
          v_emph[v] = (c - 1) * 12;
        end
      end
    end
    for (int v = 0; v < VOICE_CNT; v++) begin
      sn = v_snd[v];
      addr = (snd_start[sn] + v_pos[v]) & 16'hFFFF;
      smp = wave_mem[addr];
      vol = v_emph[v] + v_vol[v];
      if (v_pos[v] != 0) begin
        np = v_pos[v] + 1;
        v_pos[v] = (np >= snd_len[sn]) ? 0 : np;
      end
      left += vol * smp * v_pan[v];
      right += vol * smp * (32 - v_pan[v]);
    end
    frame_cnt++;
    if (frame_cnt >= spt_e) begin
      frame_cnt = 0;
      step_cnt++;
      if (step_cnt >= spb_e) begin
        step_cnt = 0;
        bar_cnt++;
        if (bar_cnt >= lb_e) bar_cnt = 0;
      end
    end
    f.left_sample = sat16(left / 32768);
    f.right_sample = sat16(right / 32768);
    expected_frames.push_back(f);
  endfunction

  function automatic void apply_beat(in_item_t b);
    case (b.opcode)
      OP_GENERATE: mix_frame();
      OP_WAVE: wave_mem[b.wave_address] = b.wave_value;
      OP_SOUND: begin
        snd_start[b.sound_id] = b.wave_address;
        snd_len[b.sound_id] = b.sound_length;
      end
      OP_PATTERN:
        if (b.voice_id < VOICE_CNT && b.step_index < N_STEPS)
          hit_grid[b.pattern_id][b.voice_id][b.step_index] =
            (b.hit_level > 9) ? 4'd9 : b.hit_level;
      OP_VOICE:
        if (b.voice_id < VOICE_CNT) begin
          v_pan[b.voice_id] = (b.pan > 32) ? 32 : b.pan;
          v_vol[b.voice_id] = b.volume;
          v_snd[b.voice_id] = b.sound_id;
        end
      OP_ARRANGE: arrange[b.bar_slot] = b.pattern_id;
      default: ;
    endcase
  endfunction

  // Input driver: one beat in flight, random idle cycles between beats.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_beat(in_data);
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted in cycles.
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 300;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Output monitor: compares each frame with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("frame with no prediction waiting: left %0d right %0d",
                 out_data.left_sample, out_data.right_sample);
          errors++;
        end else begin
          out_item_t e;
          e = expected_frames.pop_front();
          frames_checked++;
          if (out_data.left_sample !== e.left_sample) begin
            $error("left_sample expected %0d actual %0d", e.left_sample, out_data.left_sample);
            errors++;
          end
          if (out_data.right_sample !== e.right_sample) begin
            $error("right_sample expected %0d actual %0d", e.right_sample, out_data.right_sample);
            errors++;
          end
        end
      end
      // A long hold lets the block fill up and push back on its input.
      if (hold_req || hold_cnt > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 28);
      end
    end
  end

  function automatic in_item_t rand_beat(logic [2:0] op);
    in_item_t b;
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    b = r[$bits(in_item_t)-1:0];
    b.opcode = op;
    return b;
  endfunction

  task automatic send(in_item_t b);
    pending_beats.push_back(b);
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_WIDTH-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SAMPLES_PER_TICK: spt_reg = val & 16'hFFFF;
      REG_STEPS_PER_BAR: spb_reg = val & 7'h7F;
      default: lb_reg = val & 5'h1F;
    endcase
  endtask

  task automatic random_phase(int count);
    in_item_t b;
    int r, spb_e;
    spb_e = (spb_reg < 1) ? 1 : (spb_reg > N_STEPS ? N_STEPS : spb_reg);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 55) b = rand_beat(OP_GENERATE);
      else if (r < 72) begin
        b = rand_beat(OP_PATTERN);
        // Mostly cells that the current bar length will actually play.
        if ($urandom_range(3) != 0) begin
          b.step_index = 7'($urandom_range(spb_e - 1));
          b.voice_id = 3'($urandom_range(VOICE_CNT - 1));
        end
      end else if (r < 80) begin
        b = rand_beat(OP_VOICE);
        if ($urandom_range(3) != 0) b.pan = 6'($urandom_range(32));
      end else if (r < 85) b = rand_beat(OP_ARRANGE);
      else if (r < 90) begin
        b = rand_beat(OP_SOUND);
        b.wave_address = 16'($urandom_range(SND_START_MAX));
        b.sound_length = 16'($urandom_range(SND_LEN_MAX));
      end else if (r < 97) begin
        b = rand_beat(OP_WAVE);
        b.wave_address = 16'($urandom_range(LOW_WORDS - 1));
      end
      else b = rand_beat($urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7);
      send(b);
    end
  endtask

  initial begin
    in_item_t b;
    for (int p = 0; p < 4; p++)
      for (int v = 0; v < VOICE_CNT; v++)
        for (int s = 0; s < N_STEPS; s++) hit_grid[p][v][s] = '0;
    foreach (arrange[i]) arrange[i] = '0;
    for (int v = 0; v < VOICE_CNT; v++) begin
      v_pan[v] = 16; v_vol[v] = 0; v_snd[v] = 0; v_pos[v] = 0; v_emph[v] = 0;
    end
    frame_cnt = 0; step_cnt = 0; bar_cnt = 0;
    spt_reg = 948; spb_reg = 72; lb_reg = 10;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Every wave word a sound can reach and every sound entry is loaded first.
    no_idle = 1'b1;
    for (int a = 0; a < LOW_WORDS + TOP_WORDS; a++) begin
      b = rand_beat(OP_WAVE);
      b.wave_address = (a < LOW_WORDS) ? 16'(a) : 16'(65536 - TOP_WORDS + (a - LOW_WORDS));
      send(b);
    end
    for (int s = 0; s < 8; s++) begin
      b = rand_beat(OP_SOUND);
      b.sound_id = 3'(s);
      b.wave_address = 16'($urandom_range(SND_START_MAX));
      b.sound_length = 16'($urandom_range(SND_LEN_MAX));
      if (s == 0) begin b.wave_address = 16'hFFE8; b.sound_length = 16'd48; end
      if (s == 1) b.sound_length = 0;
      if (s == 2) b.sound_length = 1;
      if (s == 3) begin b.wave_address = 0; b.sound_length = 4; end
      send(b);
    end
    wait_idle();
    no_idle = 1'b0;

    // Directed beats: extremes, spare opcodes, out of range loads, hits at step zero.
    b = rand_beat(OP_WAVE); b.wave_address = 1; b.wave_value = 16'sh7FFF; send(b);
    b = rand_beat(OP_WAVE); b.wave_address = 2; b.wave_value = 16'sh8000; send(b);
    for (int v = 0; v < 8; v++) begin
      b = rand_beat(OP_VOICE);
      b.voice_id = 3'(v);
      b.volume = (v == 0) ? 8'd255 : 8'd200;
      b.pan = (v == 0) ? 6'd0 : (v == 1) ? 6'd32 : (v == 2) ? 6'd63 : 6'd20;
      b.sound_id = (v < 3) ? 3'd3 : 3'd7;
      send(b);
    end
    for (int v = 0; v < 4; v++) begin
      b = rand_beat(OP_PATTERN);
      b.pattern_id = 0; b.step_index = 0; b.voice_id = 3'(v);
      b.hit_level = (v == 0) ? 4'd9 : (v == 1) ? 4'd15 : (v == 2) ? 4'd1 : 4'd0;
      send(b);
    end
    b = rand_beat(OP_PATTERN); b.step_index = 7'd72; send(b);
    b = rand_beat(OP_PATTERN); b.step_index = 7'd127; b.voice_id = 3'd7; send(b);
    b = rand_beat(OP_ARRANGE); b.bar_slot = 4'd15; b.pattern_id = 2'd3; send(b);
    send(rand_beat(OP_SPARE_6));
    send(rand_beat(OP_SPARE_7));
    for (int k = 0; k < 6; k++) send(rand_beat(OP_GENERATE));
    wait_idle();

    // Settings phases, including zero and over-range register values.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_SAMPLES_PER_TICK, 3); write_reg(REG_STEPS_PER_BAR, 8);
                 write_reg(REG_LOOP_LEN, 4); end
        1: begin write_reg(REG_SAMPLES_PER_TICK, 1); write_reg(REG_STEPS_PER_BAR, 1);
                 write_reg(REG_LOOP_LEN, 1); end
        2: begin write_reg(REG_SAMPLES_PER_TICK, 0); write_reg(REG_STEPS_PER_BAR, 0);
                 write_reg(REG_LOOP_LEN, 0); end
        3: begin write_reg(REG_SAMPLES_PER_TICK, 65535); write_reg(REG_STEPS_PER_BAR, 72);
                 write_reg(REG_LOOP_LEN, 16); end
        4: begin write_reg(REG_SAMPLES_PER_TICK, 2); write_reg(REG_STEPS_PER_BAR, 127);
                 write_reg(REG_LOOP_LEN, 31); end
        default: begin write_reg(REG_SAMPLES_PER_TICK, 5); write_reg(REG_STEPS_PER_BAR, 20);
                 write_reg(REG_LOOP_LEN, 16); end
      endcase
      if (ph == 1) no_idle = 1'b1;
      if (ph == 4) begin
        // A run of frame beats offered while the receiver holds off.
        for (int k = 0; k < 20; k++) send(rand_beat(OP_GENERATE));
        hold_req = 1'b1;
      end
      random_phase(60);
      wait_idle();
      no_idle = 1'b0;
    end

    $display("Sent %0d beats and checked %0d stereo frames over six register settings,",
             beats_sent, frames_checked);
    $display("with random idling, a long receiver hold and a preloaded wave region.");
    if (errors == 0) begin
      $display("PASS drum_step_sequencer_mixer_top");
    end else begin
      $display("FAIL drum_step_sequencer_mixer_top");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL drum_step_sequencer_mixer_top");
    $finish;
  end

endmodule

>>> filelist.f
sv/dssm_pkg.sv
sv/drum_step_sequencer_mixer_top.sv
dv/drum_step_sequencer_mixer_top_tb.sv
